// ===== sv/nfbu_pkg.sv =====
// Shared types, constants and arithmetic helpers of the neuron forward and backprop unit.
package nfbu_pkg;

	localparam int FRAC_BITS    = 12;
	localparam int TANH_ENTRIES = 1024;
	localparam int ACC_WIDTH    = 40;

	localparam int TANH_IDX_W = $clog2(TANH_ENTRIES);
	// |sum| * TANH_ENTRIES / (4 << 2F) reduces to a right shift.
	localparam int TANH_SHIFT = 2 * FRAC_BITS + 2 - TANH_IDX_W;
	localparam int ONE_Q      = 1 << FRAC_BITS;
	localparam int CF_LEVELS  = 20;

	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 20;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	localparam logic [1:0] CMD_FORWARD  = 2'd0;
	localparam logic [1:0] CMD_OUT_GRAD = 2'd1;
	localparam logic [1:0] CMD_HID_GRAD = 2'd2;
	localparam logic [1:0] CMD_UPDATE   = 2'd3;

	localparam logic [1:0] KIND_ACTIVATION = 2'd0;
	localparam logic [1:0] KIND_GRADIENT   = 2'd1;
	localparam logic [1:0] KIND_UPDATE     = 2'd2;

	localparam logic [1:0] REG_LEARN_RATE = 2'd0;
	localparam logic [1:0] REG_MOMENTUM   = 2'd1;

	typedef enum logic [1:0] {
		OP_FWD   = 2'd0,
		OP_OGRAD = 2'd1,
		OP_HID   = 2'd2,
		OP_UPD   = 2'd3
	} op_kind_t;

	typedef struct packed {
		op_kind_t           op;
		logic signed [15:0] a;
		logic signed [15:0] b;
		logic signed [15:0] od;
		logic               last;
	} op_item_t;

	typedef struct packed {
		logic signed [15:0] value;
		logic signed [15:0] delta;
		logic [1:0]         kind;
		logic               sat;
	} result_t;

	typedef struct packed {
		logic [15:0] learn_rate;
		logic [15:0] momentum;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] value;
		logic               clipped;
	} clip_t;

	typedef logic [15:0] tanh_rom_t [TANH_ENTRIES];

	// Arithmetic right shift that rounds to nearest, ties away from zero.
	function automatic logic signed [63:0] round_shift(logic signed [63:0] v, int unsigned s);
		logic signed [63:0] bias;
		bias = 64'sd1 <<< (s - 1);
		if (v < 0) begin
			bias = bias - 64'sd1;
		end
		return (v + bias) >>> s;
	endfunction

	function automatic clip_t clip16(logic signed [63:0] v);
		clip_t r;
		r.clipped = 1'b0;
		r.value   = v[15:0];
		if (v > 64'sd32767) begin
			r.clipped = 1'b1;
			r.value   = 16'sh7fff;
		end else if (v < -64'sd32768) begin
			r.clipped = 1'b1;
			r.value   = 16'sh8000;
		end
		return r;
	endfunction

	// Truncating unsigned quotient by shift and subtract, used while the table is built.
	function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], n[i]};
			if (r >= d) begin
				r    = r - d;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// Table of tanh(i * 4 / TANH_ENTRIES) in Q.12, from a Lambert continued fraction in Q.24.
	function automatic tanh_rom_t build_tanh_rom();
		tanh_rom_t   rom;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] y;
		for (int i = 0; i < TANH_ENTRIES; i++) begin
			x  = (64'(i) << 26) / TANH_ENTRIES;
			x2 = (x * x) >> 24;
			t  = 64'(2 * CF_LEVELS + 1) << 24;
			for (int k = CF_LEVELS; k >= 1; k--) begin
				t = (64'(2 * k - 1) << 24) + udiv64(x2 << 24, t);
			end
			y = udiv64(x << 24, t);
			y = (y + (64'd1 << (23 - FRAC_BITS))) >> (24 - FRAC_BITS);
			if (y > 64'(ONE_Q)) begin
				y = 64'(ONE_Q);
			end
			rom[i] = y[15:0];
		end
		return rom;
	endfunction

endpackage

// ===== sv/nfbu_fifo.sv =====
// Small first-in first-out queue of fixed-width words.
module nfbu_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ===== sv/nfbu_front.sv =====
// Front end: accepts input words, classifies the command and hands it to the queue.
module nfbu_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [1:0]          command,
	input  logic signed [15:0]  operand_a,
	input  logic signed [15:0]  operand_b,
	input  logic signed [15:0]  old_delta,
	input  logic                last_term,
	output logic                q_push,
	output nfbu_pkg::op_item_t  q_item,
	input  logic                q_full
);

	import nfbu_pkg::*;

	logic     valid_s1;
	op_item_t item_s1;
	op_item_t decoded;
	logic     accept;

	always_comb begin
		decoded      = '0;
		decoded.a    = operand_a;
		decoded.b    = operand_b;
		decoded.od   = old_delta;
		decoded.last = last_term;
		case (command)
			CMD_FORWARD:  decoded.op = OP_FWD;
			CMD_OUT_GRAD: decoded.op = OP_OGRAD;
			CMD_HID_GRAD: decoded.op = OP_HID;
			CMD_UPDATE:   decoded.op = OP_UPD;
			default:      decoded.op = OP_FWD;
		endcase
	end

	assign full   = valid_s1 && q_full;
	assign accept = push && !full;
	assign q_push = valid_s1 && !q_full;
	assign q_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= decoded;
		end
	end

endmodule

// ===== sv/nfbu_back.sv =====
// Back end: sequencer with one shared multiplier that carries out queued operations.
module nfbu_back (
	input  logic               clk,
	input  logic               arst_n,
	input  nfbu_pkg::cfg_t     cfg,
	input  logic               cmd_empty,
	input  nfbu_pkg::op_item_t cmd_item,
	output logic               cmd_pop,
	input  logic               res_full,
	output logic               res_push,
	output nfbu_pkg::result_t  res_item
);

	import nfbu_pkg::*;

	typedef enum logic [10:0] {
		ST_IDLE      = 11'b000_0000_0001,
		ST_MUL_AB    = 11'b000_0000_0010,
		ST_ACC       = 11'b000_0000_0100,
		ST_TANH      = 11'b000_0000_1000,
		ST_MUL_OO    = 11'b000_0001_0000,
		ST_DERIV     = 11'b000_0010_0000,
		ST_MUL_GRAD  = 11'b000_0100_0000,
		ST_UPD_LR    = 11'b000_1000_0000,
		ST_UPD_MOM   = 11'b001_0000_0000,
		ST_UPD_DELTA = 11'b010_0000_0000,
		ST_FINISH    = 11'b100_0000_0000
	} state_t;

	localparam tanh_rom_t TanhRom = build_tanh_rom();
	localparam logic signed [ACC_WIDTH-1:0] AccMax = {1'b0, {(ACC_WIDTH - 1){1'b1}}};
	localparam logic signed [ACC_WIDTH-1:0] AccMin = {1'b1, {(ACC_WIDTH - 1){1'b0}}};

	state_t                        st_q;
	state_t                        st_d;
	op_item_t                      op_q;
	logic signed [PROD_W-1:0]      p_q;
	logic signed [PROD_W-1:0]      momprod_q;
	logic signed [ACC_WIDTH-1:0]   acc_q;
	logic                          accsat_q;
	logic signed [MUL_A_W-1:0]     dow_q;
	logic signed [MUL_B_W-1:0]     deriv_q;
	logic [15:0]                   rom_q;
	logic                          ovf_q;
	logic                          neg_q;
	logic signed [15:0]            delta_q;
	logic                          dsat_q;
	logic signed [15:0]            out_q;
	logic signed [15:0]            grad_q;

	logic signed [MUL_A_W-1:0]     ma;
	logic signed [MUL_B_W-1:0]     mb;
	logic signed [PROD_W-1:0]      prod;
	logic signed [ACC_WIDTH:0]     acc_sum;
	logic signed [ACC_WIDTH-1:0]   acc_new;
	logic                          acc_lim;
	logic [ACC_WIDTH-1:0]          acc_mag;
	logic [ACC_WIDTH-1:0]          tanh_idx;
	logic signed [63:0]            tanh_y;
	logic signed [63:0]            upd_sum;
	clip_t                         fin_clip;
	clip_t                         delta_clip;

	// Operand selection for the shared multiplier.
	always_comb begin
		ma = '0;
		mb = '0;
		case (st_q)
			ST_MUL_AB: begin
				ma = MUL_A_W'(op_q.a);
				mb = (op_q.op == OP_UPD) ? MUL_B_W'(grad_q) : MUL_B_W'(op_q.b);
			end
			ST_MUL_OO: begin
				ma = MUL_A_W'(out_q);
				mb = MUL_B_W'(out_q);
			end
			ST_MUL_GRAD: begin
				ma = dow_q;
				mb = deriv_q;
			end
			ST_UPD_LR: begin
				ma = p_q[MUL_A_W-1:0];
				mb = $signed({{(MUL_B_W - 16){1'b0}}, cfg.learn_rate});
			end
			ST_UPD_MOM: begin
				ma = MUL_A_W'(op_q.od);
				mb = $signed({{(MUL_B_W - 16){1'b0}}, cfg.momentum});
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign prod = PROD_W'(ma) * PROD_W'(mb);

	// Saturating accumulate of the 32-bit term product.
	always_comb begin
		acc_sum = (ACC_WIDTH + 1)'(acc_q) + (ACC_WIDTH + 1)'($signed(p_q[MUL_A_W-1:0]));
		if (acc_sum > (ACC_WIDTH + 1)'(AccMax)) begin
			acc_new = AccMax;
		end else if (acc_sum < (ACC_WIDTH + 1)'(AccMin)) begin
			acc_new = AccMin;
		end else begin
			acc_new = acc_sum[ACC_WIDTH-1:0];
		end
		acc_lim = (acc_new == AccMax) || (acc_new == AccMin);
	end

	assign acc_mag  = acc_q[ACC_WIDTH-1] ? ACC_WIDTH'(-acc_q) : ACC_WIDTH'(acc_q);
	assign tanh_idx = acc_mag >> TANH_SHIFT;

	assign upd_sum    = 64'(p_q) + (64'(momprod_q) <<< FRAC_BITS);
	assign delta_clip = clip16(round_shift(upd_sum, FRAC_BITS + 16));

	// Result formation in the finishing step.
	always_comb begin
		tanh_y   = ovf_q ? 64'(ONE_Q) : 64'($signed({1'b0, rom_q}));
		if (neg_q) begin
			tanh_y = -tanh_y;
		end
		res_item = '0;
		case (op_q.op)
			OP_FWD: begin
				fin_clip       = clip16(tanh_y);
				res_item.kind  = KIND_ACTIVATION;
				res_item.sat   = fin_clip.clipped || accsat_q;
			end
			OP_HID: begin
				fin_clip       = clip16(round_shift(64'(p_q), FRAC_BITS));
				res_item.kind  = KIND_GRADIENT;
				res_item.sat   = fin_clip.clipped || accsat_q;
			end
			OP_OGRAD: begin
				fin_clip       = clip16(round_shift(64'(p_q), FRAC_BITS));
				res_item.kind  = KIND_GRADIENT;
				res_item.sat   = fin_clip.clipped;
			end
			OP_UPD: begin
				fin_clip       = clip16(64'(op_q.b) + 64'(delta_q));
				res_item.kind  = KIND_UPDATE;
				res_item.sat   = fin_clip.clipped || dsat_q;
				res_item.delta = delta_q;
			end
			default: begin
				fin_clip       = '0;
			end
		endcase
		res_item.value = fin_clip.value;
	end

	assign cmd_pop  = (st_q == ST_IDLE) && !cmd_empty;
	assign res_push = (st_q == ST_FINISH) && !res_full;

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: begin
				if (!cmd_empty) begin
					st_d = (cmd_item.op == OP_OGRAD) ? ST_MUL_OO : ST_MUL_AB;
				end
			end
			ST_MUL_AB:    st_d = (op_q.op == OP_UPD) ? ST_UPD_LR : ST_ACC;
			ST_ACC: begin
				if (!op_q.last) begin
					st_d = ST_IDLE;
				end else if (op_q.op == OP_FWD) begin
					st_d = ST_TANH;
				end else begin
					st_d = ST_MUL_OO;
				end
			end
			ST_TANH:      st_d = ST_FINISH;
			ST_MUL_OO:    st_d = ST_DERIV;
			ST_DERIV:     st_d = ST_MUL_GRAD;
			ST_MUL_GRAD:  st_d = ST_FINISH;
			ST_UPD_LR:    st_d = ST_UPD_MOM;
			ST_UPD_MOM:   st_d = ST_UPD_DELTA;
			ST_UPD_DELTA: st_d = ST_FINISH;
			ST_FINISH: begin
				if (!res_full) begin
					st_d = ST_IDLE;
				end
			end
			default:      st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			acc_q  <= '0;
			out_q  <= '0;
			grad_q <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_ACC) begin
				acc_q <= acc_new;
			end
			if (res_push) begin
				case (op_q.op)
					OP_FWD: begin
						out_q <= res_item.value;
						acc_q <= '0;
					end
					OP_HID: begin
						grad_q <= res_item.value;
						acc_q  <= '0;
					end
					OP_OGRAD: grad_q <= res_item.value;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			op_q <= cmd_item;
		end
		if (st_q == ST_MUL_AB || st_q == ST_MUL_OO || st_q == ST_MUL_GRAD ||
		    st_q == ST_UPD_LR) begin
			p_q <= prod;
		end
		if (st_q == ST_UPD_MOM) begin
			momprod_q <= prod;
		end
		if (st_q == ST_ACC) begin
			accsat_q <= acc_lim;
		end
		if (st_q == ST_TANH) begin
			rom_q <= TanhRom[tanh_idx[TANH_IDX_W-1:0]];
			ovf_q <= |tanh_idx[ACC_WIDTH-1:TANH_IDX_W];
			neg_q <= acc_q[ACC_WIDTH-1];
		end
		if (st_q == ST_DERIV) begin
			deriv_q <= MUL_B_W'(64'(ONE_Q) - round_shift(64'(p_q), FRAC_BITS));
			if (op_q.op == OP_HID) begin
				dow_q <= MUL_A_W'(round_shift(64'(acc_q), FRAC_BITS));
			end else begin
				dow_q <= MUL_A_W'(64'(op_q.a) - 64'(out_q));
			end
		end
		if (st_q == ST_UPD_DELTA) begin
			delta_q <= delta_clip.value;
			dsat_q  <= delta_clip.clipped;
		end
	end

`ifndef SYNTH
	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> (st_q == ST_IDLE))
		else $error("operation taken from the queue while the sequencer is busy");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into a full result queue");

	a_acc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && (op_q.op == OP_FWD || op_q.op == OP_HID)) |=> (acc_q == '0))
		else $error("accumulator not cleared after the last term of a sum");

	a_tanh_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && op_q.op == OP_FWD) |->
		(17'(res_item.value) <= 17'(ONE_Q) && 17'(res_item.value) >= -17'(ONE_Q)))
		else $error("activation outside plus or minus one");
`endif

endmodule

// ===== sv/neuron_forward_backprop_unit.sv =====
// Top level of the neuron forward and backprop unit: configuration registers and queues.
//
// Usage. Input words enter like a queue: a word is taken at a rising edge of clk with push
// high and full low. Results leave like a queue: the oldest result sits on result_value,
// new_delta, result_kind and saturated while empty is low, and it is taken at an edge with
// pop high. The configuration channel writes learn_rate (index 0) or momentum (index 1)
// when cfg_valid and cfg_ready are high; cfg_ready is always high and other indexes are
// ignored. Write configuration only while the unit is idle.
// Sequence. An accepted word waits in the front register and is then queued. The back end
// runs one word at a time on its shared multiplier: a forward or hidden gradient term is
// multiplied and accumulated, and the last forward term then looks up tanh; the last hidden
// gradient term and an output gradient square the kept activation, form the slope and
// multiply by it; a weight update applies learn_rate and momentum and then forms the delta.
// Stalls. A waiting result does not stop the front end; up to CMD_DEPTH words queue up
// behind the back end, and the back end holds in its finishing step while the result queue
// is full. full rises only when the front register and the operation queue are both full.
// Reset. arst_n clears the queues, the accumulator, the kept activation and gradient, and
// loads the reset values of learn_rate and momentum.
module neuron_forward_backprop_unit #(
	parameter int CMD_DEPTH = 4,
	parameter int RES_DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         command,
	input  logic signed [15:0] operand_a,
	input  logic signed [15:0] operand_b,
	input  logic signed [15:0] old_delta,
	input  logic               last_term,
	output logic               empty,
	input  logic               pop,
	output logic signed [15:0] result_value,
	output logic signed [15:0] new_delta,
	output logic [1:0]         result_kind,
	output logic               saturated,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	import nfbu_pkg::*;

	cfg_t     cfg_q;
	logic     fq_push;
	op_item_t fq_item;
	logic     cq_full;
	logic     cq_empty;
	logic     cq_pop;
	op_item_t cq_item;
	logic [$bits(op_item_t)-1:0] cq_rdata;
	logic     rq_full;
	logic     rq_push;
	result_t  rq_item;
	result_t  rq_out;
	logic [$bits(result_t)-1:0] rq_rdata;

	// The configuration port never stalls.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.learn_rate <= 16'd9830;
			cfg_q.momentum   <= 16'd32768;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LEARN_RATE: cfg_q.learn_rate <= cfg_data;
				REG_MOMENTUM:   cfg_q.momentum   <= cfg_data;
				default: ;
			endcase
		end
	end

	nfbu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.command   (command),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.old_delta (old_delta),
		.last_term (last_term),
		.q_push    (fq_push),
		.q_item    (fq_item),
		.q_full    (cq_full)
	);

	// Operation queue between the front and back ends.
	nfbu_fifo #(
		.WIDTH ($bits(op_item_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fq_push),
		.wdata  (fq_item),
		.full   (cq_full),
		.pop    (cq_pop),
		.rdata  (cq_rdata),
		.empty  (cq_empty)
	);

	assign cq_item = op_item_t'(cq_rdata);

	nfbu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_empty (cq_empty),
		.cmd_item  (cq_item),
		.cmd_pop   (cq_pop),
		.res_full  (rq_full),
		.res_push  (rq_push),
		.res_item  (rq_item)
	);

	// Result queue; its head drives the result ports.
	nfbu_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (RES_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rq_push),
		.wdata  (rq_item),
		.full   (rq_full),
		.pop    (pop),
		.rdata  (rq_rdata),
		.empty  (empty)
	);

	assign rq_out       = result_t'(rq_rdata);
	assign result_value = rq_out.value;
	assign new_delta    = rq_out.delta;
	assign result_kind  = rq_out.kind;
	assign saturated    = rq_out.sat;

endmodule

// ===== bench/neuron_forward_backprop_unit_test.sv =====
// Self-checking bench for the neuron forward and backprop unit, predicting every result word.
`timescale 1ns / 1ps
module neuron_forward_backprop_unit_test;
	import nfbu_pkg::*;

	// The watchdog ends the run after this many cycles in which no word moves anywhere.
	localparam int WATCHDOG_LIMIT = 4000;
	// Quiet cycles allowed for a term with no result to leave the back end before a
	// register write, and for stray results to show up at the very end.
	localparam int SETTLE_CYCLES  = 64;
	// Length of the long receiver hold-off used to fill the unit up.
	localparam int HOLD_CYCLES    = 400;
	localparam int REPORT_LIMIT   = 10;
	localparam int PHASE_WORDS    = 150;

	// Indexes past the two registers; writes there must change nothing.
	localparam logic [1:0] REG_SPARE_LO = 2'd2;
	localparam logic [1:0] REG_SPARE_HI = 2'd3;

	localparam longint ACC_HI = (longint'(1) << (ACC_WIDTH - 1)) - 1;
	localparam longint ACC_LO = -(longint'(1) << (ACC_WIDTH - 1));

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               push         = 1'b0;
	logic               full;
	logic [1:0]         command      = OP_FWD;
	logic signed [15:0] operand_a    = '0;
	logic signed [15:0] operand_b    = '0;
	logic signed [15:0] old_delta    = '0;
	logic               last_term    = 1'b0;
	logic               empty;
	logic               pop          = 1'b0;
	logic signed [15:0] result_value;
	logic signed [15:0] new_delta;
	logic [1:0]         result_kind;
	logic               saturated;
	logic               cfg_valid    = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index    = REG_LEARN_RATE;
	logic [15:0]        cfg_data     = '0;

	neuron_forward_backprop_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.command      (command),
		.operand_a    (operand_a),
		.operand_b    (operand_b),
		.old_delta    (old_delta),
		.last_term    (last_term),
		.empty        (empty),
		.pop          (pop),
		.result_value (result_value),
		.new_delta    (new_delta),
		.result_kind  (result_kind),
		.saturated    (saturated),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Mirror of the neuron: its sum, the kept activation and gradient, and both registers.
	longint  tanh_lut [TANH_ENTRIES];
	longint  acc_sum   = 0;
	longint  kept_out  = 0;
	longint  kept_grad = 0;
	longint  eta_q16   = 9830;
	longint  alpha_q16 = 32768;
	result_t pending_results [$];

	int   fail_count    = 0;
	int   send_idle_pct = 0;
	int   pop_stall_pct = 0;
	// Flipping this asks the pop process for one long hold-off.
	logic hold_toggle   = 1'b0;

	// Right shift rounding to nearest, with ties going away from zero.
	function automatic longint round_shr(longint v, int s);
		longint mag;
		mag = (v < 0) ? -v : v;
		mag = (mag + (longint'(1) << (s - 1))) >>> s;
		return (v < 0) ? -mag : mag;
	endfunction

	function automatic logic signed [15:0] clamp16(longint v, inout bit clipped);
		if (v > 32767) begin
			clipped = 1'b1;
			return 16'sh7fff;
		end
		if (v < -32768) begin
			clipped = 1'b1;
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	// Slope of tanh at the kept activation: 1 - out^2.
	function automatic longint act_slope();
		return ONE_Q - round_shr(kept_out * kept_out, FRAC_BITS);
	endfunction

	// tanh over [0, 4) in TANH_ENTRIES steps, from a Lambert continued fraction evaluated
	// bottom up in Q.24 with truncating division, then rounded to the result format.
	function automatic void fill_tanh_lut();
		longint unsigned x;
		longint unsigned xsq;
		longint unsigned den;
		longint unsigned q;
		for (int i = 0; i < TANH_ENTRIES; i++) begin
			x   = (longint'(i) << 26) / TANH_ENTRIES;
			xsq = (x * x) >> 24;
			den = longint'(2 * CF_LEVELS + 1) << 24;
			for (int k = CF_LEVELS; k >= 1; k--) begin
				den = (longint'(2 * k - 1) << 24) + (xsq << 24) / den;
			end
			q = (x << 24) / den;
			q = (q + (longint'(1) << (23 - FRAC_BITS))) >> (24 - FRAC_BITS);
			tanh_lut[i] = (q > ONE_Q) ? ONE_Q : q;
		end
	endfunction

	// Advances the mirror by one accepted word; returns 1 when that word yields a result.
	function automatic bit neuron_predict(op_item_t w, output result_t r);
		longint a;
		longint b;
		longint od;
		longint mag;
		longint idx;
		longint y;
		longint raw_delta;
		bit     clipped;
		a       = longint'(w.a);
		b       = longint'(w.b);
		od      = longint'(w.od);
		r       = '0;
		clipped = 1'b0;
		case (w.op)
			OP_FWD, OP_HID: begin
				// Forward and hidden terms share one saturating accumulator.
				acc_sum = acc_sum + a * b;
				if (acc_sum > ACC_HI) begin
					acc_sum = ACC_HI;
				end
				if (acc_sum < ACC_LO) begin
					acc_sum = ACC_LO;
				end
				if (!w.last) begin
					return 1'b0;
				end
				clipped = (acc_sum == ACC_HI) || (acc_sum == ACC_LO);
				if (w.op == OP_FWD) begin
					mag = (acc_sum < 0) ? -acc_sum : acc_sum;
					idx = (mag * TANH_ENTRIES) / (longint'(4) << (2 * FRAC_BITS));
					y   = (idx >= TANH_ENTRIES) ? longint'(ONE_Q) :
						tanh_lut[idx[TANH_IDX_W-1:0]];
					if (acc_sum < 0) begin
						y = -y;
					end
					r.value  = clamp16(y, clipped);
					r.kind   = KIND_ACTIVATION;
					kept_out = longint'(r.value);
				end else begin
					r.value   = clamp16(round_shr(round_shr(acc_sum, FRAC_BITS) * act_slope(),
						FRAC_BITS), clipped);
					r.kind    = KIND_GRADIENT;
					kept_grad = longint'(r.value);
				end
				acc_sum = 0;
			end
			OP_OGRAD: begin
				r.value   = clamp16(round_shr((a - kept_out) * act_slope(), FRAC_BITS), clipped);
				r.kind    = KIND_GRADIENT;
				kept_grad = longint'(r.value);
			end
			default: begin
				// The new weight is built from the delta after it has been clipped.
				raw_delta = a * kept_grad * eta_q16 + od * alpha_q16 * ONE_Q;
				r.delta   = clamp16(round_shr(raw_delta, FRAC_BITS + 16), clipped);
				r.value   = clamp16(b + longint'(r.delta), clipped);
				r.kind    = KIND_UPDATE;
			end
		endcase
		r.sat = clipped;
		return 1'b1;
	endfunction

	// Mostly values near the useful range of tanh, with full-scale values mixed in.
	function automatic logic signed [15:0] rand_operand();
		case ($urandom_range(5))
			0:       return 16'($urandom);
			1:       return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
			default: return 16'(int'($urandom_range(12287)) - 6144);
		endcase
	endfunction

	task automatic log_failure(string what, result_t want, result_t got);
		fail_count++;
		if (fail_count <= REPORT_LIMIT) begin
			$display("%0t %s: expected value %0d delta %0d kind %0d sat %0d", $time, what,
				want.value, want.delta, want.kind, want.sat);
			$display("    actual value %0d delta %0d kind %0d sat %0d",
				got.value, got.delta, got.kind, got.sat);
		end
	endtask

	// Offers one word, after a random gap when the sender is idling, and waits until the
	// unit takes it. push is left high so that the next word can follow back to back.
	task automatic send_word(op_kind_t op, logic signed [15:0] a, logic signed [15:0] b,
		logic signed [15:0] od, logic last);
		op_item_t w;
		result_t  r;
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			do begin
				@(posedge clk);
			end while ($urandom_range(99) < send_idle_pct);
		end
		push      <= 1'b1;
		command   <= op;
		operand_a <= a;
		operand_b <= b;
		old_delta <= od;
		last_term <= last;
		do begin
			@(posedge clk);
		end while (full);
		w = '{op: op, a: a, b: b, od: od, last: last};
		if (neuron_predict(w, r)) begin
			pending_results.push_back(r);
		end
	endtask

	// Stops offering words, waits for every expected result, then lets a trailing term
	// with no result clear the back end.
	task automatic wait_until_idle();
		push <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic [1:0] idx, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		case (idx)
			REG_LEARN_RATE: eta_q16 = longint'(data);
			REG_MOMENTUM:   alpha_q16 = longint'(data);
			default: ;
		endcase
	endtask

	// Writes both registers, then one index past them that must leave both alone.
	task automatic write_config(logic [15:0] eta, logic [15:0] alpha);
		wait_until_idle();
		write_register(REG_LEARN_RATE, eta);
		write_register(REG_MOMENTUM, alpha);
		write_register($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// Single-term sums at both rails and at zero, a short sum, and a forward term that
	// bleeds into a hidden gradient sum through the shared accumulator.
	task automatic test_forward_terms();
		send_word(OP_FWD, 16'sh7fff, 16'sh7fff, '0, 1'b1);
		send_word(OP_FWD, 16'sh8000, 16'sh7fff, '0, 1'b1);
		send_word(OP_FWD, 16'sh0000, 16'sh0000, '0, 1'b1);
		send_word(OP_FWD, 16'sh1000, 16'sh0800, '0, 1'b0);
		send_word(OP_FWD, -16'sh1000, 16'sh0400, '0, 1'b0);
		send_word(OP_FWD, 16'sh0800, 16'sh0800, '0, 1'b1);
		send_word(OP_FWD, 16'sh1000, 16'sh1000, '0, 1'b0);
		send_word(OP_HID, 16'sh1000, 16'sh1000, '0, 1'b1);
	endtask

	// Output gradients with extreme targets, and hidden gradients that clip both ways.
	task automatic test_gradients();
		send_word(OP_FWD, 16'sh1000, 16'sh0800, '0, 1'b1);
		send_word(OP_OGRAD, 16'sh7fff, '0, '0, 1'b0);
		send_word(OP_OGRAD, 16'sh8000, '0, '0, 1'b1);
		send_word(OP_HID, 16'sh7fff, 16'sh7fff, '0, 1'b1);
		send_word(OP_HID, 16'sh8000, 16'sh7fff, '0, 1'b1);
	endtask

	// Weight updates that clip the delta and the new weight, under the reset rates and
	// then under the largest and smallest rates.
	task automatic test_weight_updates();
		send_word(OP_UPD, 16'sh7fff, 16'sh0000, 16'sh0000, 1'b0);
		send_word(OP_UPD, 16'sh0000, 16'sh7fff, 16'sh7fff, 1'b1);
		send_word(OP_UPD, 16'sh0000, 16'sh8000, 16'sh8000, 1'b0);
		send_word(OP_UPD, 16'sh0000, 16'sh0064, 16'sh0000, 1'b0);
		write_config(16'hffff, 16'hffff);
		send_word(OP_UPD, 16'sh8000, 16'sh0000, 16'sh8000, 1'b0);
		write_config(16'h0000, 16'h0000);
		send_word(OP_UPD, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1);
	endtask

	// Long sums of full-scale products drive the accumulator into its upper and then its
	// lower limit; the closing results must carry the saturation flag.
	task automatic test_accumulator_limits();
		repeat (520) send_word(OP_FWD, 16'sh8000, 16'sh8000, rand_operand(), 1'b0);
		send_word(OP_FWD, 16'sh8000, 16'sh8000, '0, 1'b1);
		repeat (520) send_word(OP_HID, 16'sh8000, 16'sh7fff, rand_operand(), 1'b0);
		send_word(OP_HID, 16'sh8000, 16'sh7fff, '0, 1'b1);
	endtask

	// Mostly complete sums, gradients and updates with random content; the rest is
	// arbitrary words, including stray terms that split or merge sums.
	task automatic test_random_traffic(int send_pct, int pop_pct, logic [15:0] eta,
		logic [15:0] alpha);
		int sent;
		int pick;
		int terms;
		write_config(eta, alpha);
		send_idle_pct = send_pct;
		pop_stall_pct = pop_pct;
		sent          = 0;
		while (sent < PHASE_WORDS) begin
			pick  = $urandom_range(99);
			terms = $urandom_range(1, 6);
			if (pick < 30) begin
				for (int t = 1; t <= terms; t++) begin
					send_word(OP_FWD, rand_operand(), rand_operand(), 16'($urandom),
						t == terms);
				end
				sent += terms;
			end else if (pick < 45) begin
				send_word(OP_OGRAD, rand_operand(), 16'($urandom), 16'($urandom),
					1'($urandom_range(1)));
				sent++;
			end else if (pick < 65) begin
				for (int t = 1; t <= terms; t++) begin
					send_word(OP_HID, rand_operand(), rand_operand(), 16'($urandom),
						t == terms);
				end
				sent += terms;
			end else if (pick < 85) begin
				send_word(OP_UPD, rand_operand(), rand_operand(), rand_operand(),
					1'($urandom_range(1)));
				sent++;
			end else begin
				send_word(op_kind_t'($urandom_range(3)), 16'($urandom), 16'($urandom),
					16'($urandom), 1'($urandom_range(1)));
				sent++;
			end
		end
	endtask

	// The receiver stops for a long stretch while updates keep coming, so the result
	// queue and then the operation queue fill and full holds the sender off.
	task automatic test_backpressure();
		hold_toggle <= ~hold_toggle;
		repeat (24) send_word(OP_UPD, rand_operand(), rand_operand(), rand_operand(), 1'b0);
	endtask

	// Receiver: pops at random per the stall rate, or holds off for HOLD_CYCLES when asked.
	logic hold_seen = 1'b0;
	int   hold_left = 0;

	always @(posedge clk) begin
		if (hold_toggle != hold_seen) begin
			hold_seen <= hold_toggle;
			hold_left <= HOLD_CYCLES;
			pop       <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			pop       <= 1'b0;
		end else begin
			pop <= !(pop_stall_pct != 0 && $urandom_range(99) < pop_stall_pct);
		end
	end

	// Every popped word is checked against the oldest expected result.
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && pop && !empty) begin
			got = '{value: result_value, delta: new_delta, kind: result_kind, sat: saturated};
			if (pending_results.size() == 0) begin
				log_failure("result word with nothing expected", '0, got);
			end else begin
				want = pending_results.pop_front();
				if (got.value !== want.value || got.delta !== want.delta ||
					got.kind !== want.kind || got.sat !== want.sat) begin
					log_failure("result word mismatch", want, got);
				end
			end
		end
	end

	// A run that stops moving words for too long has hung or lost a result.
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("** neuron_forward_backprop_unit: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		fill_tanh_lut();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed words run with no idling on either side, starting under the reset rates.
		test_forward_terms();
		test_gradients();
		test_weight_updates();
		test_accumulator_limits();

		test_random_traffic(0, 0, 16'hffff, 16'h0000);
		test_random_traffic(47, 0, 16'h0000, 16'hffff);
		test_random_traffic(0, 47, 16'($urandom), 16'($urandom));
		test_random_traffic(29, 29, 16'($urandom), 16'($urandom));
		test_backpressure();

		pop_stall_pct = 0;
		wait_until_idle();
		if (fail_count == 0) begin
			$display("** neuron_forward_backprop_unit: PASSED **");
		end else begin
			$display("** neuron_forward_backprop_unit: FAILED **");
		end
		$finish;
	end

endmodule
